@@ rtl/euler_rigid_point_transform_top_macros.svh @@
// assertion macros for the point transform checker
`ifndef EULER_RIGID_POINT_TRANSFORM_TOP_MACROS_SVH
`define EULER_RIGID_POINT_TRANSFORM_TOP_MACROS_SVH
`define ERPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
`define ERPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

@@ rtl/erpt_pkg.sv @@
// ----------------------------------------------------------------------------
// erpt_pkg
// shared types, constants and the cordic angle table for the point transform
// ----------------------------------------------------------------------------
package erpt_pkg;
	localparam int NUM_REGS = 6;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHZ = 3'd5;
	localparam int TABLE_LEN = 24;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

	typedef logic signed [17:0] entry_t;
	typedef logic signed [31:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef enum logic [2:0] {
		MB_IDLE,
		MB_CORDIC,
		MB_PROD1,
		MB_PROD2,
		MB_DONE
	} mb_state_t;

	function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0: r = 34'sh020000000;
			5'd1: r = 34'sh012E4051E;
			5'd2: r = 34'sh009FB385B;
			5'd3: r = 34'sh0051111D4;
			5'd4: r = 34'sh0028B0D43;
			5'd5: r = 34'sh00145D7E1;
			5'd6: r = 34'sh000A2F61E;
			5'd7: r = 34'sh000517C55;
			5'd8: r = 34'sh00028BE53;
			5'd9: r = 34'sh000145F2F;
			5'd10: r = 34'sh0000A2F98;
			5'd11: r = 34'sh0000517CC;
			5'd12: r = 34'sh000028BE6;
			5'd13: r = 34'sh0000145F3;
			5'd14: r = 34'sh000000A2FA;
			5'd15: r = 34'sh00000517D;
			5'd16: r = 34'sh0000028BE;
			5'd17: r = 34'sh00000145F;
			5'd18: r = 34'sh000000A30;
			5'd19: r = 34'sh000000518;
			5'd20: r = 34'sh00000028C;
			5'd21: r = 34'sh000000146;
			5'd22: r = 34'sh0000000A3;
			5'd23: r = 34'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

@@ rtl/erpt_matrix_build.sv @@
// ----------------------------------------------------------------------------
// erpt_matrix_build
// iterative cordic for the three angles, then the nine matrix entries
// ----------------------------------------------------------------------------
module erpt_matrix_build import erpt_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] roll,
	input  logic signed [15:0] pitch,
	input  logic signed [15:0] yaw,
	output logic               done,
	output entry_t             mat [9]
);
	localparam int SW = 5;
	localparam logic [SW-1:0] LAST = SW'(CORDIC_STEPS - 1);

	mb_state_t state_q, state_d;
	logic [SW-1:0] step_q;
	logic signed [33:0] x_q [3];
	logic signed [33:0] y_q [3];
	logic signed [33:0] z_q [3];
	logic flip_q [3];
	logic signed [17:0] c_q [3];
	logic signed [17:0] s_q [3];
	logic signed [35:0] p_q [6];
	logic [3:0] ecnt_q;
	logic signed [63:0] acc_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			MB_IDLE: if (start) state_d = MB_CORDIC;
			MB_CORDIC: if (step_q == LAST) state_d = MB_PROD1;
			MB_PROD1: state_d = MB_PROD2;
			MB_PROD2: if (ecnt_q == 4'd8) state_d = MB_DONE;
			MB_DONE: state_d = MB_IDLE;
			default: state_d = MB_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MB_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign done = (state_q == MB_DONE);

	function automatic logic signed [17:0] rnd14(input logic signed [33:0] v, input logic f);
		logic signed [33:0] t;
		logic signed [17:0] r;
		t = (v + 34'sd8192) >>> 14;
		r = t[17:0];
		return f ? -r : r;
	endfunction

	logic signed [15:0] ang [3];
	assign ang[0] = roll;
	assign ang[1] = pitch;
	assign ang[2] = yaw;

	logic signed [63:0] q48;
	always_comb begin
		case (ecnt_q)
			4'd0: q48 = (64'(c_q[2]) * 64'(c_q[1])) <<< 16;
			4'd1: q48 = 64'(p_q[1]) * 64'(s_q[0]) - (64'(p_q[2]) <<< 16);
			4'd2: q48 = 64'(p_q[1]) * 64'(c_q[0]) + (64'(p_q[3]) <<< 16);
			4'd3: q48 = 64'(p_q[4]) <<< 16;
			4'd4: q48 = 64'(p_q[5]) * 64'(s_q[0]) + (64'(p_q[0]) * 0 + (64'(acc_q) <<< 16));
			4'd5: q48 = 64'(p_q[5]) * 64'(c_q[0]) - ((64'(c_q[2]) * 64'(s_q[0])) <<< 16);
			4'd6: q48 = -(64'(s_q[1]) <<< 32);
			4'd7: q48 = 64'(c_q[1]) * 64'(s_q[0]) <<< 16;
			default: q48 = 64'(c_q[1]) * 64'(c_q[0]) <<< 16;
		endcase
	end

	logic signed [63:0] rr;
	logic signed [17:0] ent;
	always_comb begin
		rr = (q48 + 64'sh80000000) >>> 32;
		if (rr > 64'sd131071) ent = 18'sd131071;
		else if (rr < -64'sd131072) ent = -18'sd131072;
		else ent = rr[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			ecnt_q <= '0;
			for (int k = 0; k < 9; k++) mat[k] <= '0;
		end else begin
			case (state_q)
				MB_IDLE: begin
					step_q <= '0;
					ecnt_q <= '0;
				end
				MB_CORDIC: step_q <= step_q + SW'(1);
				MB_PROD2: begin
					mat[ecnt_q] <= ent;
					ecnt_q <= ecnt_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MB_IDLE: if (start) begin
				for (int k = 0; k < 3; k++) begin
					logic [31:0] a;
					a = {ang[k], 16'h0};
					flip_q[k] <= (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
					if ((a[31:30] == 2'b01) || (a[31:30] == 2'b10)) a = a + 32'h80000000;
					x_q[k] <= CORDIC_GAIN;
					y_q[k] <= '0;
					z_q[k] <= 34'(signed'(a));
				end
			end
			MB_CORDIC: begin
				for (int k = 0; k < 3; k++) begin
					logic signed [33:0] dx, dy;
					dx = y_q[k] >>> step_q;
					dy = x_q[k] >>> step_q;
					if (!z_q[k][33]) begin
						x_q[k] <= x_q[k] - dx;
						y_q[k] <= y_q[k] + dy;
						z_q[k] <= z_q[k] - atan_entry(step_q);
					end else begin
						x_q[k] <= x_q[k] + dx;
						y_q[k] <= y_q[k] - dy;
						z_q[k] <= z_q[k] + atan_entry(step_q);
					end
				end
			end
			MB_PROD1: begin
				for (int k = 0; k < 3; k++) begin
					c_q[k] <= rnd14(x_q[k], flip_q[k]);
					s_q[k] <= rnd14(y_q[k], flip_q[k]);
				end
			end
			MB_PROD2: if (ecnt_q == 4'd0) begin
				// products: cy*cp, cy*sp, sy*cr, sy*sr, sy*cp, sy*sp
				p_q[0] <= 36'(c_q[2]) * 36'(c_q[1]);
				p_q[1] <= 36'(c_q[2]) * 36'(s_q[1]);
				p_q[2] <= 36'(s_q[2]) * 36'(c_q[0]);
				p_q[3] <= 36'(s_q[2]) * 36'(s_q[0]);
				p_q[4] <= 36'(s_q[2]) * 36'(c_q[1]);
				p_q[5] <= 36'(s_q[2]) * 36'(s_q[1]);
				acc_q <= 64'(36'(c_q[2]) * 36'(c_q[0]));
			end
			default: ;
		endcase
	end
endmodule

@@ rtl/erpt_point_queue.sv @@
// ----------------------------------------------------------------------------
// erpt_point_queue
// short fifo between the accepting front and the arithmetic back end
// ----------------------------------------------------------------------------
module erpt_point_queue import erpt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  point_t wr_data,
	output logic   rd_valid,
	input  logic   rd_ready,
	output point_t rd_data
);
	point_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr_en, rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
endmodule

@@ rtl/erpt_point_pipe.sv @@
// ----------------------------------------------------------------------------
// erpt_point_pipe
// three stage multiply, sum and saturate pipeline with elastic output
// ----------------------------------------------------------------------------
module erpt_point_pipe import erpt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  point_t pt,
	input  entry_t mat [9],
	input  coord_t shift [3],
	output logic   out_valid,
	input  logic   out_ready,
	output coord_t res [3],
	output logic   sat
);
	logic v_s1, v_s2, v_s3;
	logic signed [49:0] prod_s1 [9];
	logic signed [31:0] sh_s1 [3];
	logic signed [52:0] sum_s2 [3];
	logic adv;

	assign adv = !v_s3 || out_ready;
	assign in_ready = adv;
	assign out_valid = v_s3;

	coord_t pj [3];
	assign pj[0] = pt.x;
	assign pj[1] = pt.y;
	assign pj[2] = pt.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) prod_s1[i] <= 50'(mat[i]) * 50'(pj[i % 3]);
			for (int i = 0; i < 3; i++) sh_s1[i] <= shift[i];
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= 53'(prod_s1[3*i]) + 53'(prod_s1[3*i+1]) + 53'(prod_s1[3*i+2])
					+ (53'(sh_s1[i]) <<< 16) + 53'sd32768;
			end
			begin
				logic any;
				logic signed [36:0] r;
				any = 1'b0;
				for (int i = 0; i < 3; i++) begin
					r = 37'(sum_s2[i] >>> 16);
					if (r > 37'sd2147483647) begin
						res[i] <= 32'sh7FFFFFFF;
						any = 1'b1;
					end else if (r < -37'sd2147483648) begin
						res[i] <= 32'sh80000000;
						any = 1'b1;
					end else begin
						res[i] <= r[31:0];
					end
				end
				sat <= any;
			end
		end
	end
endmodule

@@ rtl/euler_rigid_point_transform_top.sv @@
// ----------------------------------------------------------------------------
// euler_rigid_point_transform_top
// rotates and translates a point stream by a configured rigid transform
// ----------------------------------------------------------------------------
// channels: cfg (index, data) writes the angles and shifts; the user is to
// write them only while idle, the block does not enforce it. points enter on
// in_valid/in_ready and leave on out_valid/out_ready, one result per request,
// in order. after reset or a config write to one of the six registers the
// matrix is stale; the next point waits in the queue while the iterative
// cordic rebuilds it in the shared cordic step loop and serial entry rounding.
// with a fresh matrix one point is accepted per cycle while the pipe is not
// stalled; it passes the multiply, sum and saturate stages after the queue.
// when the receiver stalls the pipe holds, the two entry queue fills, then
// in_ready drops. reset clears control state, config and matrix registers only.
// ----------------------------------------------------------------------------
module euler_rigid_point_transform_top import erpt_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   in_x,
	input  logic signed [31:0]   in_y,
	input  logic signed [31:0]   in_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   out_x,
	output logic signed [31:0]   out_y,
	output logic signed [31:0]   out_z,
	output logic                 saturated
);
	logic signed [15:0] ang_q [3];
	coord_t shift_q [3];
	logic ready_q, busy_q;
	logic build_start, build_done;
	entry_t mat [9];
	logic q_valid, q_ready, pp_ready;
	point_t q_data, in_pt;
	coord_t res [3];
	logic [7:0] frac_unused;

	assign frac_unused = 8'(COORD_FRAC_BITS);
	assign cfg_ready = 1'b1;
	assign in_pt = '{x: in_x, y: in_y, z: in_z};
	assign build_start = !ready_q && !busy_q && q_valid && (frac_unused != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) ang_q[k] <= '0;
			for (int k = 0; k < 3; k++) shift_q[k] <= '0;
			ready_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (build_start) busy_q <= 1'b1;
			if (build_done) begin
				busy_q <= 1'b0;
				ready_q <= 1'b1;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_ROLL: ang_q[0] <= cfg_data[15:0];
					REG_PITCH: ang_q[1] <= cfg_data[15:0];
					REG_YAW: ang_q[2] <= cfg_data[15:0];
					REG_SHX: shift_q[0] <= cfg_data;
					REG_SHY: shift_q[1] <= cfg_data;
					REG_SHZ: shift_q[2] <= cfg_data;
					default: ;
				endcase
				if (cfg_index < CFG_IDX_W'(NUM_REGS)) ready_q <= 1'b0;
			end
		end
	end

	erpt_matrix_build #(.CORDIC_STEPS(CORDIC_STEPS)) u_build (
		.clk(clk), .arst_n(arst_n), .start(build_start),
		.roll(ang_q[0]), .pitch(ang_q[1]), .yaw(ang_q[2]),
		.done(build_done), .mat(mat)
	);

	erpt_point_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_pt),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	assign q_ready = ready_q && pp_ready;

	erpt_point_pipe u_pipe (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid && ready_q), .in_ready(pp_ready), .pt(q_data),
		.mat(mat), .shift(shift_q),
		.out_valid(out_valid), .out_ready(out_ready), .res(res), .sat(saturated)
	);

	assign out_x = res[0];
	assign out_y = res[1];
	assign out_z = res[2];
endmodule

@@ rtl/erpt_checker.sv @@
// ----------------------------------------------------------------------------
// erpt_checker
// port level checks on the point transform, bound to the top level
// ----------------------------------------------------------------------------
`include "euler_rigid_point_transform_top_macros.svh"
module erpt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic saturated,
	input logic signed [31:0] out_x
);
	`ERPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ERPT_ASSERT_NEXT(a_x_hold, clk, arst_n, out_valid && !out_ready, $stable(out_x))
	`ERPT_ASSERT_IMPL(a_sat_known, clk, arst_n, out_valid, !$isunknown(saturated))
	`ERPT_ASSERT_NEXT(a_stall_ready, clk, arst_n, out_valid && !out_ready && !in_ready,
		!in_ready || out_ready)
endmodule

bind euler_rigid_point_transform_top erpt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .saturated(saturated), .out_x(out_x)
);
